/* rtl/nca_pkg.sv */
// ----------------------------------------------------------------------------
// nca_pkg: shared types and codes
// Pond entry layout, command codes and controller states.
// ----------------------------------------------------------------------------
package nca_pkg;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_ASSIGN = 1'b1;

    // One pond entry as held in a cell of the ring.
    typedef struct packed {
        logic        used;
        logic        full;
        logic [31:0] east;
        logic [31:0] north;
        logic [15:0] label;
        logic [31:0] room;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

endpackage

/* rtl/nca_cell.sv */
// ----------------------------------------------------------------------------
// nca_cell: one pond slot of the rotating ring
// Holds one entry, passes it on to its neighbor when the ring turns.
// ----------------------------------------------------------------------------
module nca_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  nca_pkg::t_entry i_prev,
    input  logic            i_load,
    input  nca_pkg::t_entry i_load_data,
    input  logic            i_upd,
    input  logic [31:0]     i_upd_room,
    input  logic            i_upd_full,
    output nca_pkg::t_entry o_q
);

    nca_pkg::t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.used <= 1'b0;
            r_q.full <= 1'b0;
        end else if (i_load) begin
            r_q <= i_load_data;
        end else if (i_upd) begin
            r_q.room <= i_upd_room;
            r_q.full <= i_upd_full;
        end else if (i_shift) begin
            r_q <= i_prev;
        end
    end

    assign o_q = r_q;

endmodule

/* rtl/nca_dist.sv */
// ----------------------------------------------------------------------------
// nca_dist: squared distance pipeline
// Stage one takes absolute differences, stage two squares them.
// ----------------------------------------------------------------------------
module nca_dist #(
    parameter int IDX_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_issue,
    input  logic             i_ok,
    input  logic [IDX_W-1:0] i_idx,
    input  nca_pkg::t_entry  i_entry,
    input  logic [31:0]      i_px,
    input  logic [31:0]      i_py,
    output logic             o_valid,
    output logic [IDX_W-1:0] o_idx,
    output nca_pkg::t_entry  o_entry,
    output logic [63:0]      o_sx,
    output logic [63:0]      o_sy,
    output logic             o_busy
);

    logic             r1_v, r1_ok, r2_v, r2_ok;
    logic [IDX_W-1:0] r1_idx, r2_idx;
    nca_pkg::t_entry  r1_entry, r2_entry;
    logic [31:0]      r1_dx, r1_dy;
    logic [63:0]      r2_sx, r2_sy;
    logic [32:0]      w_ddx, w_ddy, w_mx, w_my;

    always_comb begin
        w_ddx = {i_px[31], i_px} - {i_entry.east[31], i_entry.east};
        w_ddy = {i_py[31], i_py} - {i_entry.north[31], i_entry.north};
        w_mx  = w_ddx[32] ? (33'd0 - w_ddx) : w_ddx;
        w_my  = w_ddy[32] ? (33'd0 - w_ddy) : w_ddy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            r1_v <= i_issue;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ok    <= i_ok;
        r1_idx   <= i_idx;
        r1_entry <= i_entry;
        r1_dx    <= w_mx[31:0];
        r1_dy    <= w_my[31:0];
        r2_ok    <= r1_ok;
        r2_idx   <= r1_idx;
        r2_entry <= r1_entry;
        r2_sx    <= r1_dx * r1_dx;
        r2_sy    <= r1_dy * r1_dy;
    end

    assign o_valid = r2_v && r2_ok;
    assign o_idx   = r2_idx;
    assign o_entry = r2_entry;
    assign o_sx    = r2_sx;
    assign o_sy    = r2_sy;
    assign o_busy  = r1_v || r2_v;

endmodule

/* rtl/nearest_capacity_assigner.sv */
// ----------------------------------------------------------------------------
// nearest_capacity_assigner: greedy nearest-pond volume placement
// Loads a table of ponds and pours cut volumes into the nearest open ponds.
// ----------------------------------------------------------------------------
// The ponds live in a ring of POND_DEPTH cells. A load item (tuser = 0) writes
// the next free cell; loads past the table depth are dropped. An assign item
// (tuser = 1) runs one nearest search per result item it produces. Each search
// turns the ring once and feeds one entry per cycle into a two-stage
// squared-distance pipeline. Each pipeline result is compared against the best
// candidate so far. The search then drains the pipeline and emits a result
// item, which waits while the output side still holds an earlier item. The block
// takes one input item at a time. Ties in distance go to the lower table
// index. When no open pond remains, one item with tuser (none left) set and
// zero payload closes the cut.
module nearest_capacity_assigner #(
    parameter int POND_DEPTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // [31:0] point_x, [63:32] point_y, [79:64] pond_number, [111:80] volume
    input  logic [111:0]  s_tdata,
    // [0] command
    input  logic          s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // [15:0] pond label, [47:16] pond easting, [79:48] pond northing
    output logic [79:0]   m_tdata,
    // [0] none_left
    output logic          m_tuser,
    output logic          m_tlast
);

    localparam int TOT_W = $clog2(POND_DEPTH + 1);
    localparam int IDX_W = (POND_DEPTH > 1) ? $clog2(POND_DEPTH) : 1;

    nca_pkg::t_state  r_state;
    logic [TOT_W-1:0] r_total;
    logic [IDX_W-1:0] r_cnt;
    logic [31:0]      r_px, r_py, r_vol;
    logic             r_found;
    logic [64:0]      r_best_d;
    logic [IDX_W-1:0] r_best_idx;
    nca_pkg::t_entry  r_best;
    logic             r_m_valid, r_m_none, r_m_last;
    logic [79:0]      r_m_data;

    nca_pkg::t_entry  w_q [POND_DEPTH];
    nca_pkg::t_entry  w_load_data;
    logic             w_accept, w_load, w_shift, w_emit, w_fit, w_exact;
    logic [31:0]      n_room, n_vol;
    logic             n_full;

    logic             w_dv, w_busy;
    logic [IDX_W-1:0] w_didx;
    nca_pkg::t_entry  w_dentry;
    logic [63:0]      w_sx, w_sy;
    logic [64:0]      w_sum;

    assign s_tready = (r_state == nca_pkg::ST_IDLE);
    assign w_accept = s_tvalid && s_tready;
    assign w_load   = w_accept && (s_tuser == nca_pkg::CMD_LOAD)
                      && (r_total < TOT_W'(POND_DEPTH));
    assign w_shift  = (r_state == nca_pkg::ST_SCAN);
    assign w_emit   = (r_state == nca_pkg::ST_EMIT) && (!r_m_valid || m_tready);

    always_comb begin
        w_load_data.used  = 1'b1;
        w_load_data.full  = 1'b0;
        w_load_data.east  = s_tdata[31:0];
        w_load_data.north = s_tdata[63:32];
        w_load_data.label = s_tdata[79:64];
        w_load_data.room  = s_tdata[111:80];
    end

    // The ring turns toward cell zero; cell zero feeds the distance pipeline.
    for (genvar k = 0; k < POND_DEPTH; k++) begin : g_ring
        nca_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift     (w_shift),
            .i_prev      (w_q[(k + 1) % POND_DEPTH]),
            .i_load      (w_load && (r_total == TOT_W'(k))),
            .i_load_data (w_load_data),
            .i_upd       (w_emit && r_found && (r_best_idx == IDX_W'(k))),
            .i_upd_room  (n_room),
            .i_upd_full  (n_full),
            .o_q         (w_q[k])
        );
    end

    nca_dist #(.IDX_W(IDX_W)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (w_shift),
        .i_ok    (w_q[0].used && !w_q[0].full),
        .i_idx   (r_cnt),
        .i_entry (w_q[0]),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_valid (w_dv),
        .o_idx   (w_didx),
        .o_entry (w_dentry),
        .o_sx    (w_sx),
        .o_sy    (w_sy),
        .o_busy  (w_busy)
    );

    assign w_sum = {1'b0, w_sx} + {1'b0, w_sy};

    // Pour decision for the chosen pond.
    always_comb begin
        w_fit   = (r_best.room >= r_vol);
        w_exact = (r_best.room == r_vol);
        if (w_fit) begin
            n_room = r_best.room - r_vol;
            n_full = w_exact;
            n_vol  = r_vol;
        end else begin
            n_room = 32'd0;
            n_full = 1'b1;
            n_vol  = r_vol - r_best.room;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= nca_pkg::ST_IDLE;
            r_total   <= '0;
            r_cnt     <= '0;
            r_found   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_m_valid && m_tready) begin
                r_m_valid <= 1'b0;
            end
            if (w_load) begin
                r_total <= r_total + TOT_W'(1);
            end
            if (w_dv && (!r_found || (w_sum < r_best_d))) begin
                r_found    <= 1'b1;
                r_best_d   <= w_sum;
                r_best_idx <= w_didx;
                r_best     <= w_dentry;
            end
            unique case (r_state)
                nca_pkg::ST_IDLE: begin
                    if (w_accept && (s_tuser == nca_pkg::CMD_ASSIGN)) begin
                        r_px    <= s_tdata[31:0];
                        r_py    <= s_tdata[63:32];
                        r_vol   <= s_tdata[111:80];
                        r_found <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= nca_pkg::ST_SCAN;
                    end
                end
                nca_pkg::ST_SCAN: begin
                    r_cnt <= r_cnt + IDX_W'(1);
                    if (r_cnt == IDX_W'(POND_DEPTH - 1)) begin
                        r_state <= nca_pkg::ST_DRAIN;
                    end
                end
                nca_pkg::ST_DRAIN: begin
                    if (!w_busy) begin
                        r_state <= nca_pkg::ST_EMIT;
                    end
                end
                nca_pkg::ST_EMIT: begin
                    if (w_emit) begin
                        r_m_valid <= 1'b1;
                        if (!r_found) begin
                            r_m_data <= '0;
                            r_m_none <= 1'b1;
                            r_m_last <= 1'b1;
                            r_state  <= nca_pkg::ST_IDLE;
                        end else begin
                            r_m_data <= {r_best.north, r_best.east, r_best.label};
                            r_m_none <= 1'b0;
                            r_m_last <= w_fit;
                            r_vol    <= n_vol;
                            r_found  <= 1'b0;
                            r_cnt    <= '0;
                            r_state  <= w_fit ? nca_pkg::ST_IDLE : nca_pkg::ST_SCAN;
                        end
                    end
                end
                default: r_state <= nca_pkg::ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_none;
    assign m_tlast  = r_m_last;

    // The pond count never runs past the table depth.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TOT_W'(POND_DEPTH))
        else $error("pond count exceeds table depth");

    // A load into a full table leaves the count alone.
    a_drop_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_tuser == nca_pkg::CMD_LOAD && r_total == TOT_W'(POND_DEPTH))
        |=> $stable(r_total))
        else $error("dropped load changed the pond count");

    // A chosen pond always lies inside the loaded part of the table.
    a_best_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nca_pkg::ST_EMIT && r_found)
        |-> ({1'b0, r_best_idx} < (IDX_W + 1)'(r_total)))
        else $error("chosen pond outside loaded table");

    // A none-left item ends the cut and carries no pond.
    a_none_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("none-left item malformed");

endmodule

/* tb/nearest_capacity_assigner_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_capacity_assigner_checker: pond table predictor and result checker
// Watches both channels, predicts every result item from a private copy of
// the pond table and compares each delivered item field by field.
// ----------------------------------------------------------------------------
module nearest_capacity_assigner_checker #(
    parameter int POND_DEPTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [111:0] i_s_tdata,
    input  logic         i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [79:0]  i_m_tdata,
    input  logic         i_m_tuser,
    input  logic         i_m_tlast,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        logic [15:0] label;
        logic [31:0] px;
        logic [31:0] py;
        logic        none_left;
        logic        last;
    } t_placement;

    logic [31:0] east_q  [POND_DEPTH];
    logic [31:0] north_q [POND_DEPTH];
    logic [15:0] label_q [POND_DEPTH];
    logic [31:0] room_q  [POND_DEPTH];
    logic        full_q  [POND_DEPTH];
    int          loaded;

    t_placement placements_due[$];

    assign o_pending = placements_due.size();

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    // Appends one expected result item at the tail of the queue.
    task automatic add_placement(input logic [15:0] lab, input logic [31:0] ex,
                                 input logic [31:0] ny, input logic none,
                                 input logic fin);
        t_placement p;
        p.label     = lab;
        p.px        = ex;
        p.py        = ny;
        p.none_left = none;
        p.last      = fin;
        placements_due.insert(placements_due.size(), p);
    endtask

    // Exact squared distance, widened to 66 bits so no carry is lost.
    function automatic logic [65:0] dist_sq(input logic [31:0] ax, input logic [31:0] ay,
                                            input logic [31:0] bx, input logic [31:0] by);
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        dx = $signed({{2{ax[31]}}, ax}) - $signed({{2{bx[31]}}, bx});
        dy = $signed({{2{ay[31]}}, ay}) - $signed({{2{by[31]}}, by});
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy);
    endfunction

    task automatic predict_pour(input logic [31:0] cx, input logic [31:0] cy,
                                input logic [31:0] amount);
        int          best;
        logic [65:0] best_d;
        logic [65:0] d;
        logic [31:0] left;
        left = amount;
        forever begin
            best = -1;
            best_d = '0;
            for (int i = 0; i < loaded; i++) begin
                if (!full_q[i]) begin
                    d = dist_sq(cx, cy, east_q[i], north_q[i]);
                    if (best < 0 || d < best_d) begin
                        best = i;
                        best_d = d;
                    end
                end
            end
            if (best < 0) begin
                add_placement(16'd0, 32'd0, 32'd0, 1'b1, 1'b1);
                return;
            end
            if (room_q[best] >= left) begin
                if (room_q[best] == left) full_q[best] = 1'b1;
                room_q[best] -= left;
                add_placement(label_q[best], east_q[best], north_q[best], 1'b0, 1'b1);
                return;
            end
            left -= room_q[best];
            room_q[best] = '0;
            full_q[best] = 1'b1;
            add_placement(label_q[best], east_q[best], north_q[best], 1'b0, 1'b0);
        end
    endtask

    always @(posedge i_clk) begin
        t_placement want;
        if (!i_rst_n) begin
            loaded <= 0;
            o_fail_count <= 0;
            for (int i = 0; i < POND_DEPTH; i++) full_q[i] <= 1'b0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == nca_pkg::CMD_LOAD) begin
                    if (loaded < POND_DEPTH) begin
                        east_q[loaded]  = i_s_tdata[31:0];
                        north_q[loaded] = i_s_tdata[63:32];
                        label_q[loaded] = i_s_tdata[79:64];
                        room_q[loaded]  = i_s_tdata[111:80];
                        full_q[loaded]  = 1'b0;
                        loaded = loaded + 1;
                    end
                end else begin
                    predict_pour(i_s_tdata[31:0], i_s_tdata[63:32], i_s_tdata[111:80]);
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (placements_due.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    want = placements_due.pop_front();
                    if (i_m_tdata[15:0] != want.label)
                        report_mismatch($sformatf("label %h, expected %h",
                                                  i_m_tdata[15:0], want.label));
                    if (i_m_tdata[47:16] != want.px)
                        report_mismatch($sformatf("x %h, expected %h",
                                                  i_m_tdata[47:16], want.px));
                    if (i_m_tdata[79:48] != want.py)
                        report_mismatch($sformatf("y %h, expected %h",
                                                  i_m_tdata[79:48], want.py));
                    if (i_m_tuser != want.none_left)
                        report_mismatch($sformatf("none_left %b, expected %b",
                                                  i_m_tuser, want.none_left));
                    if (i_m_tlast != want.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  i_m_tlast, want.last));
                end
            end
        end
    end

endmodule

/* tb/nearest_capacity_assigner_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_capacity_assigner_tb: stimulus and verdict for the pond assigner
// Loads pond tables, sends directed and random cut items with random gaps and
// stalls on both sides, and lets the checker judge every result item.
// ----------------------------------------------------------------------------
module nearest_capacity_assigner_tb;

    localparam int POND_DEPTH = 32;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;  // [31:0] x, [63:32] y, [79:64] label, [111:80] volume
    logic         s_tuser;  // [0] command
    logic         m_tvalid;
    logic         m_tready;
    logic [79:0]  m_tdata;  // [15:0] label, [47:16] x, [79:48] y
    logic         m_tuser;  // [0] none_left
    logic         m_tlast;

    int fail_count;
    int pending;

    // The sender's idling can be switched off to give a stretch of full rate.
    bit send_steady;
    // The receiver's idling mode: 0 random, 1 always ready, 2 long hold-off.
    int drain_mode;

    nearest_capacity_assigner #(.POND_DEPTH(POND_DEPTH)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    nearest_capacity_assigner_checker #(.POND_DEPTH(POND_DEPTH)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_m_tlast   (m_tlast),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Worst case is about 500 items * 33 results each; this timeout is ample.
    initial begin
        #10000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stalls, a clean stretch, and one long hold-off counted
    // here so the block backs up and must stall its input.
    initial begin
        int hold;
        m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (drain_mode == 2) begin
                m_tready <= 1'b0;
                for (hold = 0; hold < 600; hold++) @(posedge i_clk);
                drain_mode = 0;
            end
            if (drain_mode == 1) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(99) >= 27);
        end
    end

    // One item through the input channel; the valid is held across
    // back-to-back items and only dropped for random idle cycles.
    task automatic send_item(input logic cmd, input logic [31:0] x, input logic [31:0] y,
                             input logic [15:0] lab, input logic [31:0] vol);
        while (!send_steady && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {vol, lab, y, x};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic settle;
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Random coordinate: mostly small to force near ties, sometimes full range.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(20)) - 10);
            default: return 32'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    function automatic logic [31:0] rand_volume();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'd0;
            default: return $urandom_range(100);
        endcase
    endfunction

    initial begin
        int n;
        s_tvalid = 1'b0;
        s_tuser = nca_pkg::CMD_LOAD;
        s_tdata = '0;
        send_steady = 1'b0;
        drain_mode = 0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: cut into an empty table, then extremes and a tie.
        send_item(nca_pkg::CMD_ASSIGN, 32'h0, 32'h0, 16'h0, 32'd5);
        send_item(nca_pkg::CMD_LOAD, 32'h8000_0000, 32'h8000_0000, 16'hFFFF,
                  32'hFFFF_FFFF);
        send_item(nca_pkg::CMD_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0001, 32'd0);
        send_item(nca_pkg::CMD_LOAD, 32'd10, 32'd0, 16'h00A0, 32'd7);
        send_item(nca_pkg::CMD_LOAD, 32'hFFFF_FFF6, 32'd0, 16'h00A1, 32'd7);
        // Tie between the two ponds at distance 10: lower index first.
        send_item(nca_pkg::CMD_ASSIGN, 32'd0, 32'd0, 16'h1234, 32'd3);
        send_item(nca_pkg::CMD_ASSIGN, 32'd0, 32'd0, 16'h0, 32'd4);   // exact fit
        send_item(nca_pkg::CMD_ASSIGN, 32'd0, 32'd0, 16'h0, 32'd0);   // zero cut
        // Cut placed into the pond that was loaded with zero room.
        send_item(nca_pkg::CMD_ASSIGN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0, 32'd1);
        send_item(nca_pkg::CMD_ASSIGN, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0,
                  32'hFFFF_FFFF);
        // Spills over every pond until none is left.
        send_item(nca_pkg::CMD_ASSIGN, 32'h0, 32'h0, 16'h0, 32'hFFFF_FFFF);
        // Overfill the table so loads past its depth are dropped.
        for (int i = 0; i < POND_DEPTH; i++)
            send_item(nca_pkg::CMD_LOAD, rand_coord(), rand_coord(), 16'($urandom()),
                      rand_volume());
        send_item(nca_pkg::CMD_ASSIGN, rand_coord(), rand_coord(), 16'h0, 32'hFFFF_FFFF);
        settle();

        // Random part. The table never empties, so most cuts pour into ponds;
        // once every pond is full only none-left results come back.
        send_steady = 1'b1;
        drain_mode = 1;
        n = 0;
        while (n < 500) begin
            if (n == 60) begin
                send_steady = 1'b0;
                drain_mode = 2;
            end
            if (n == 120) drain_mode = 0;
            if ($urandom_range(99) < 12)
                send_item(nca_pkg::CMD_LOAD, rand_coord(), rand_coord(),
                          16'($urandom()), rand_volume());
            else
                send_item(nca_pkg::CMD_ASSIGN, rand_coord(), rand_coord(),
                          16'($urandom()), rand_volume());
            n++;
        end
        settle();
        repeat (100) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
